// File: hdl/fmul_pkg.sv
package fmul_pkg;

    localparam int unsigned BIAS      = 127;
    localparam int unsigned EXP_MAX   = 255;
    localparam int unsigned MANT_BITS = 24;
    localparam int unsigned PROD_TOP  = 47;

    typedef enum logic [2:0] {
        EXC_NONE      = 3'd0,
        EXC_INVALID   = 3'd1,
        EXC_DENORMAL  = 3'd2,
        EXC_MIX       = 3'd3,
        EXC_OVERFLOW  = 3'd4,
        EXC_UNDERFLOW = 3'd5
    } exc_t;

    // word carried from cell to cell
    typedef struct packed {
        logic        sign;
        logic        special;
        exc_t        exc;
        logic [31:0] spec_word;
        logic [9:0]  exp;
        logic [23:0] ma;
        logic [23:0] mb;
        logic [47:0] prod;
    } fmul_word_t;

endpackage

// File: hdl/fmul_cell.sv
module fmul_cell #(
    parameter int unsigned STAGE = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               vin,
    input  fmul_pkg::fmul_word_t win,
    output logic               vout,
    output fmul_pkg::fmul_word_t wout
);

    fmul_pkg::fmul_word_t w_next;
    fmul_pkg::fmul_word_t w_reg;
    logic                 v_reg;
    logic [35:0]          part;
    logic [47:0]          p;
    logic [9:0]           e;
    logic [24:0]          mant;
    logic                 rnd;
    logic                 rz;
    logic                 uf;

    always_comb
    begin
        w_next = win;
        part   = '0;
        p      = win.prod;
        e      = win.exp;
        mant   = '0;
        rnd    = 1'b0;
        rz     = 1'b0;
        uf     = 1'b0;
        case (STAGE)
            0:
            begin
                part        = win.ma[11:0] * win.mb;
                w_next.prod = {12'd0, part};
            end
            1:
            begin
                part        = win.ma[23:12] * win.mb;
                w_next.prod = win.prod + {part, 12'd0};
            end
            default:
            begin
                if (p[fmul_pkg::PROD_TOP])
                begin
                    e = e + 10'd1;
                    p = p >> 1;
                end
                // underflow is decided before rounding
                uf   = ($signed(e) <= 0);
                mant = p[47:23];
                rz   = (p[21:0] == 22'd0);
                rnd  = p[22] & (p[23] | ~rz);
                mant = mant + {24'd0, rnd};
                if (mant[fmul_pkg::MANT_BITS])
                begin
                    mant = mant >> 1;
                    e    = e + 10'd1;
                end
                if (!win.special)
                begin
                    if ($signed(e) >= $signed(10'(fmul_pkg::EXP_MAX)))
                    begin
                        w_next.exc       = fmul_pkg::EXC_OVERFLOW;
                        w_next.spec_word = '0;
                    end
                    else if (uf)
                    begin
                        w_next.exc       = fmul_pkg::EXC_UNDERFLOW;
                        w_next.spec_word = '0;
                    end
                    else
                    begin
                        w_next.exc       = fmul_pkg::EXC_NONE;
                        w_next.spec_word = {win.sign, e[7:0], mant[22:0]};
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            w_reg <= w_next;
    end

    assign vout = v_reg;
    assign wout = w_reg;

endmodule

// File: hdl/float32_multiplier_with_exceptions_unit.sv
// channel | dir | tdata (low bit up)              | tuser
// s_axis  | in  | operand_a[31:0], operand_b[31:0] | -
// m_axis  | out | product[31:0]                    | exception_code[2:0]
// one word per cycle unless the output stalls; the path runs through three cells
// (two 12x24 partial products, then normalize and round)
// the whole chain advances when the output register is empty or being read
// reset clears the valid bits only
module float32_multiplier_with_exceptions_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // operand_a, operand_b
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // product
    output logic [2:0]  m_axis_tuser    // exception_code
);

    localparam int unsigned NCELL = 3;

    fmul_pkg::fmul_word_t w [NCELL+1];
    logic                 v [NCELL+1];
    fmul_pkg::fmul_word_t w_in;
    logic                 en;
    logic [31:0]          a;
    logic [31:0]          b;
    logic [7:0]           ea, eb;
    logic                 za, zb, xa, xb, fz, sg;

    assign en            = ~m_axis_tvalid | m_axis_tready;
    assign s_axis_tready = en;
    assign a  = s_axis_tdata[31:0];
    assign b  = s_axis_tdata[63:32];
    assign ea = a[30:23];
    assign eb = b[30:23];
    assign za = (ea == 8'd0);
    assign zb = (eb == 8'd0);
    assign xa = (ea == 8'hff);
    assign xb = (eb == 8'hff);
    assign fz = (a[22:0] == 23'd0) && (b[22:0] == 23'd0);
    assign sg = a[31] ^ b[31];

    always_comb
    begin
        w_in         = '0;
        w_in.sign    = sg;
        w_in.special = 1'b1;
        w_in.ma      = {1'b1, a[22:0]};
        w_in.mb      = {1'b1, b[22:0]};
        w_in.exp     = {2'b00, ea} + {2'b00, eb} - 10'(fmul_pkg::BIAS);
        w_in.exc     = fmul_pkg::EXC_NONE;
        if ((za && zb) || ((za || zb) && !xa && !xb))
        begin
            w_in.exc       = fz ? fmul_pkg::EXC_NONE : fmul_pkg::EXC_DENORMAL;
            w_in.spec_word = fz ? {sg, 31'd0} : 32'd0;
        end
        else if ((xa && xb) || ((xa || xb) && !za && !zb))
        begin
            w_in.exc       = fz ? fmul_pkg::EXC_NONE : fmul_pkg::EXC_INVALID;
            w_in.spec_word = fz ? {sg, 8'hff, 23'd0} : 32'd0;
        end
        else if ((za && xb) || (xa && zb))
        begin
            w_in.exc = fz ? fmul_pkg::EXC_INVALID : fmul_pkg::EXC_MIX;
        end
        else
        begin
            w_in.special = 1'b0;
        end
    end

    assign w[0] = w_in;
    assign v[0] = s_axis_tvalid;

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        fmul_cell #(.STAGE(i)) u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (en),
            .vin  (v[i]),
            .win  (w[i]),
            .vout (v[i+1]),
            .wout (w[i+1])
        );
    end

    assign m_axis_tvalid = v[NCELL];
    assign m_axis_tdata  = w[NCELL].spec_word;
    assign m_axis_tuser  = w[NCELL].exc;

    a_exc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != fmul_pkg::EXC_NONE) |-> m_axis_tdata == 32'd0)
        else $error("exception with nonzero product");
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser <= 3'd5)
        else $error("bad exception code");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output state");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output word dropped while stalled");

endmodule
